// ----- rtl/rlrp_pkg.sv -----
// shared types and codes for the run-length record and playback block
// no dependencies; imported by rlrp_core and the top level
package rlrp_pkg;

  // width of one stored run length, enough for MAX_RUN up to 255
  localparam int unsigned LEN_W = 8;

  typedef enum logic {
    KIND_RECORD = 1'b0,
    KIND_PLAY   = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_RECORDED = 2'd0,
    ST_PLAYED   = 2'd1,
    ST_FINISHED = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

endpackage

// ----- rtl/rlrp_core.sv -----
// run store, record and playback counters, and the result register
// depends on rlrp_pkg; instantiated by run_length_record_playback_top
module rlrp_core import rlrp_pkg::*; #(
  parameter int unsigned RUN_DEPTH   = 1024,
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned MAX_RUN     = 255,
  localparam int unsigned IW = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1,
  localparam int unsigned CW = $clog2(RUN_DEPTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   item_valid_i,
  input  kind_e                  item_kind_i,
  input  logic [VALUE_WIDTH-1:0] item_value_i,
  output logic                   result_valid_o,
  output status_e                status_o,
  output logic [VALUE_WIDTH-1:0] out_value_o,
  output logic [CW-1:0]          runs_used_o
);

  // closed runs
  logic [VALUE_WIDTH-1:0] val_mem [RUN_DEPTH];
  logic [LEN_W-1:0]       len_mem [RUN_DEPTH];

  // entry at play_run_q, read ahead from the next pointer play_run_d
  logic [VALUE_WIDTH-1:0] cur_val_q;
  logic [LEN_W-1:0]       cur_len_q;

  logic [CW-1:0]          run_total_q, run_total_d;
  logic [CW-1:0]          play_run_q, play_run_d;
  logic [LEN_W-1:0]       play_used_q, play_used_d;
  logic [LEN_W-1:0]       open_len_q, open_len_d;
  logic [VALUE_WIDTH-1:0] open_val_q, open_val_d;

  logic                   valid_q;
  status_e                status_q, status_d;
  logic [VALUE_WIDTH-1:0] out_value_q, out_value_d;
  logic [CW-1:0]          runs_used_q, runs_used_d;

  logic                   wr_en;
  logic [IW-1:0]          wr_addr;
  logic [IW-1:0]          rd_addr;

  always_comb begin
    logic                   have_open;
    logic                   have_run;
    logic [VALUE_WIDTH-1:0] play_val;
    logic [LEN_W-1:0]       play_len;
    logic [LEN_W:0]         used_inc;

    run_total_d = run_total_q;
    play_run_d  = play_run_q;
    play_used_d = play_used_q;
    open_len_d  = open_len_q;
    open_val_d  = open_val_q;
    status_d    = ST_RECORDED;
    out_value_d = '0;
    wr_en       = 1'b0;
    wr_addr     = run_total_q[IW-1:0];
    have_open   = (open_len_q != '0);
    have_run    = 1'b0;
    play_val    = open_val_q;
    play_len    = open_len_q;
    used_inc    = {1'b0, play_used_q} + (LEN_W + 1)'(1);

    if (item_valid_i) begin
      if (item_kind_i == KIND_RECORD) begin
        if (!have_open) begin
          open_val_d = item_value_i;
          open_len_d = LEN_W'(1);
        end else if (item_value_i == open_val_q && open_len_q < LEN_W'(MAX_RUN)) begin
          open_len_d = open_len_q + LEN_W'(1);
        end else if (run_total_q >= CW'(RUN_DEPTH - 1)) begin
          status_d = ST_FULL;
        end else begin
          // close the open run into the store and open a new one
          wr_en       = 1'b1;
          run_total_d = run_total_q + CW'(1);
          open_val_d  = item_value_i;
          open_len_d  = LEN_W'(1);
        end
      end else begin
        if (play_run_q < run_total_q) begin
          have_run = 1'b1;
          play_val = cur_val_q;
          play_len = cur_len_q;
        end else if (play_run_q == run_total_q && have_open) begin
          have_run = 1'b1;
        end
        if (have_run) begin
          status_d    = ST_PLAYED;
          out_value_d = play_val;
          if (used_inc >= {1'b0, play_len}) begin
            play_run_d  = play_run_q + CW'(1);
            play_used_d = '0;
          end else begin
            play_used_d = used_inc[LEN_W-1:0];
          end
        end else begin
          status_d = ST_FINISHED;
        end
      end
    end

    runs_used_d = run_total_d + CW'(open_len_d != '0);
    rd_addr     = play_run_d[IW-1:0];
  end

  // store write and prefetch read, with write-through when both hit one entry
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      val_mem[wr_addr] <= open_val_q;
      len_mem[wr_addr] <= open_len_q;
    end
    if (wr_en && wr_addr == rd_addr) begin
      cur_val_q <= open_val_q;
      cur_len_q <= open_len_q;
    end else begin
      cur_val_q <= val_mem[rd_addr];
      cur_len_q <= len_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_total_q <= '0;
      play_run_q  <= '0;
      play_used_q <= '0;
      open_len_q  <= '0;
      open_val_q  <= '0;
      valid_q     <= 1'b0;
    end else begin
      run_total_q <= run_total_d;
      play_run_q  <= play_run_d;
      play_used_q <= play_used_d;
      open_len_q  <= open_len_d;
      open_val_q  <= open_val_d;
      valid_q     <= item_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q    <= status_d;
    out_value_q <= out_value_d;
    runs_used_q <= runs_used_d;
  end

  assign result_valid_o = valid_q;
  assign status_o       = status_q;
  assign out_value_o    = out_value_q;
  assign runs_used_o    = runs_used_q;

  // one past the closed runs once the open run has been played out
  a_play_behind_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    play_run_q <= run_total_q + CW'(1))
    else $error("playback pointer ran past the open run");

  a_total_in_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_total_q < CW'(RUN_DEPTH))
    else $error("closed run count left no room for the open run");

  a_open_len_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_len_q <= LEN_W'(MAX_RUN))
    else $error("open run grew beyond its limit");

  a_full_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_i && status_d == ST_FULL)
      |=> ($stable(run_total_q) && $stable(open_len_q) && $stable(open_val_q)))
    else $error("dropped sample changed the recording");

  a_result_follows_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_i |=> result_valid_o)
    else $error("item produced no result");

endmodule

// ----- rtl/run_length_record_playback_top.sv -----
// top level of the run-length record and playback block
// depends on rlrp_pkg and rlrp_core
//
// Records samples as runs of equal values (raw bit compare, at most MAX_RUN samples
// per run, up to RUN_DEPTH runs counting the open one) and plays them back one sample
// per request without destroying the recording. A transfer is taken on every clock
// edge where start_i is high; busy_o is never raised, so one request can be issued
// every cycle. Each request yields exactly one result, which goes through the input
// register and then the result register; the input register holds the request while
// the update logic loads it, and the result is taken at the edge ending its cycle.
// result_valid_o is high for a single cycle and the result is gone after
// it, so the receiver must capture it then; there is no way to hold results off.
// The one-per-cycle rate comes from the run store's read port fetching the entry
// at the next playback position ahead of time, with write-through when the run
// being closed is the one about to be played. The store needs no clearing after
// reset. status_o: 0 recorded, 1 played (value on out_value_o), 2 playback finished,
// 3 store full and sample dropped; runs_used_o counts runs held after the request.
module run_length_record_playback_top import rlrp_pkg::*; #(
  parameter int unsigned RUN_DEPTH   = 1024,
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned MAX_RUN     = 255
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic                               kind_i,
  input  logic [VALUE_WIDTH-1:0]             sample_value_i,
  output logic                               result_valid_o,
  output logic [1:0]                         status_o,
  output logic [VALUE_WIDTH-1:0]             out_value_o,
  output logic [$clog2(RUN_DEPTH + 1)-1:0]   runs_used_o
);

  // input register
  logic                   in_valid_q;
  kind_e                  in_kind_q;
  logic [VALUE_WIDTH-1:0] in_value_q;
  status_e                status;

  // no multi-cycle work anywhere, so every request is taken
  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i && !busy_o;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      in_kind_q  <= kind_e'(kind_i);
      in_value_q <= sample_value_i;
    end
  end

  rlrp_core #(
    .RUN_DEPTH   (RUN_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_RUN     (MAX_RUN)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (in_valid_q),
    .item_kind_i    (in_kind_q),
    .item_value_i   (in_value_q),
    .result_valid_o (result_valid_o),
    .status_o       (status),
    .out_value_o    (out_value_o),
    .runs_used_o    (runs_used_o)
  );

  assign status_o = status;

endmodule

// ----- tb/run_length_record_playback_top_tb.sv -----
// self-checking testbench for the run-length record and playback block
// depends on rlrp_pkg and run_length_record_playback_top; needs nothing else
// random gaps on the request side, a shadow copy of the run store predicts every result
module run_length_record_playback_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rlrp_pkg::*;

  localparam int unsigned RUN_DEPTH    = 1024;
  localparam int unsigned VALUE_WIDTH  = 32;
  localparam int unsigned MAX_RUN      = 255;
  localparam int unsigned RUNS_W       = $clog2(RUN_DEPTH + 1);
  // filling the store and growing the open run take most of the item count
  localparam int unsigned RANDOM_ITEMS = 200;
  localparam int unsigned LIMIT_CYCLES = 600000;
  localparam int unsigned MAX_PRINTED  = 30;

  // one request as it goes onto the command ports
  typedef struct {
    kind_e                  kind;
    logic [VALUE_WIDTH-1:0] value;
  } request_t;

  // one result as the block should present it
  typedef struct packed {
    status_e                status;
    logic [VALUE_WIDTH-1:0] value;
    logic [RUNS_W-1:0]      runs;
  } rle_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start_i = 1'b0;
  logic                   kind_i = KIND_RECORD;
  logic [VALUE_WIDTH-1:0] sample_value_i = '0;
  logic                   busy_o;
  logic                   result_valid_o;
  logic [1:0]             status_o;
  logic [VALUE_WIDTH-1:0] out_value_o;
  logic [RUNS_W-1:0]      runs_used_o;

  run_length_record_playback_top #(
    .RUN_DEPTH  (RUN_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH),
    .MAX_RUN    (MAX_RUN)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .kind_i        (kind_i),
    .sample_value_i(sample_value_i),
    .result_valid_o(result_valid_o),
    .status_o      (status_o),
    .out_value_o   (out_value_o),
    .runs_used_o   (runs_used_o)
  );

  // 20 ns clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // shadow copy of the recording: closed runs in arrays, newest run open,
  // playback cursor as run index plus samples already taken from it
  // ---------------------------------------------------------------------------
  logic [VALUE_WIDTH-1:0] shadow_val [RUN_DEPTH];
  int unsigned            shadow_len [RUN_DEPTH];
  int unsigned            closed_runs = 0;
  int unsigned            open_len    = 0;
  logic [VALUE_WIDTH-1:0] open_val    = '0;
  int unsigned            cursor_run  = 0;
  int unsigned            cursor_used = 0;
  int unsigned            peak_runs   = 0;

  request_t    stim_q[$];
  rle_result_t pending_results[$];
  int unsigned n_pushed   = 0;
  int unsigned n_accepted = 0;
  int unsigned n_errors   = 0;
  int unsigned n_status [4];
  int unsigned cycle_count = 0;

  // applies one request to the shadow recording and returns what the block must report
  function automatic rle_result_t step_recording(kind_e kind, logic [VALUE_WIDTH-1:0] smp);
    rle_result_t            r;
    logic                   hit;
    logic [VALUE_WIDTH-1:0] run_value;
    int unsigned            run_length;
    r.status   = ST_RECORDED;
    r.value    = '0;
    hit        = 1'b0;
    run_value  = '0;
    run_length = 0;
    if (kind == KIND_RECORD) begin
      if (open_len == 0) begin
        // empty recording: first sample opens a run, nothing stored ahead of it
        open_val = smp;
        open_len = 1;
      end else if (smp == open_val && open_len < MAX_RUN) begin
        open_len++;
      end else if (closed_runs + 1 >= RUN_DEPTH) begin
        // a new run is needed but the store is full: sample is dropped
        r.status = ST_FULL;
      end else begin
        // close the open run (value change or run at its limit) and start a new one
        shadow_val[closed_runs] = open_val;
        shadow_len[closed_runs] = open_len;
        closed_runs++;
        open_val = smp;
        open_len = 1;
      end
    end else begin
      if (cursor_run < closed_runs) begin
        run_value  = shadow_val[cursor_run];
        run_length = shadow_len[cursor_run];
        hit        = 1'b1;
      end else if (cursor_run == closed_runs && open_len != 0) begin
        run_value  = open_val;
        run_length = open_len;
        hit        = 1'b1;
      end
      if (hit) begin
        r.status = ST_PLAYED;
        r.value  = run_value;
        cursor_used++;
        if (cursor_used >= run_length) begin
          cursor_run++;
          cursor_used = 0;
        end
      end else begin
        // playback past the end of the recording
        r.status = ST_FINISHED;
      end
    end
    r.runs = RUNS_W'(closed_runs + (open_len != 0 ? 1 : 0));
    if (closed_runs + (open_len != 0 ? 1 : 0) > peak_runs) begin
      peak_runs = closed_runs + (open_len != 0 ? 1 : 0);
    end
    return r;
  endfunction

  task automatic push_request(kind_e kind, logic [VALUE_WIDTH-1:0] value);
    request_t req;
    req.kind  = kind;
    req.value = value;
    stim_q.push_back(req);
    n_pushed++;
  endtask

  // prints one line per failure, quiet after the first few but always counting
  task automatic flag_mismatch(string what);
    n_errors++;
    if (n_errors <= MAX_PRINTED) begin
      $display("%0t ns: mismatch %0d: %s", $time, n_errors, what);
    end
  endtask

  // ---------------------------------------------------------------------------
  // request side gaps: mostly back to back or short, a few long,
  // and now and then a stretch with no gaps at all
  // ---------------------------------------------------------------------------
  int unsigned steady_left = 0;

  function automatic int unsigned draw_gap();
    int unsigned sel;
    if (steady_left > 0) begin
      steady_left--;
      return 0;
    end
    sel = $urandom_range(0, 99);
    if (sel < 2) begin
      steady_left = $urandom_range(30, 90);
      return 0;
    end
    if (sel < 55) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: a transfer happens at an edge with start_i high and busy_o low;
  // the request is applied to the shadow recording at that same edge
  // ---------------------------------------------------------------------------
  int unsigned gap_left = 0;
  logic        holding;
  request_t    next_req;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      holding = start_i;
      if (start_i && !busy_o) begin
        pending_results.push_back(step_recording(kind_e'(kind_i), sample_value_i));
        n_accepted++;
        holding = 1'b0;
      end
      // while held off the request stays on the ports untouched
      if (!holding) begin
        if (gap_left > 0) begin
          gap_left--;
          start_i        <= 1'b0;
          sample_value_i <= $urandom();
        end else if (stim_q.size() != 0) begin
          next_req        = stim_q.pop_front();
          start_i        <= 1'b1;
          kind_i         <= next_req.kind;
          sample_value_i <= next_req.value;
          gap_left        = draw_gap();
        end else begin
          start_i        <= 1'b0;
          sample_value_i <= $urandom();
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every strobed result is checked against the oldest expectation
  // ---------------------------------------------------------------------------
  rle_result_t want;

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result with nothing outstanding: status %0d value %h runs %0d",
                                status_o, out_value_o, runs_used_o));
      end else begin
        want = pending_results.pop_front();
        n_status[want.status]++;
        if (status_o !== want.status) begin
          flag_mismatch($sformatf("status got %0d want %0d", status_o, want.status));
        end
        if (out_value_o !== want.value) begin
          flag_mismatch($sformatf("out_value got %h want %h", out_value_o, want.value));
        end
        if (runs_used_o !== want.runs) begin
          flag_mismatch($sformatf("runs_used got %0d want %0d", runs_used_o, want.runs));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d of %0d transfers taken",
               cycle_count, n_accepted, n_pushed);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // waits until every queued request has been taken and its result seen
  task automatic drain_requests();
    int unsigned n;
    while (n_accepted != n_pushed) @(posedge clk_i);
    for (n = 0; n < 100 && pending_results.size() != 0; n++) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [VALUE_WIDTH-1:0] pool [4];
    logic [VALUE_WIDTH-1:0] v;
    int unsigned            budget;
    int unsigned            len;
    int unsigned            sel;
    int unsigned            need;
    int unsigned            i;

    pool[0] = '0;
    pool[1] = '1;
    pool[2] = 32'h0000_0001;
    pool[3] = 32'h8000_0000;

    // directed: empty playback, first sample, finished then refilled,
    // field extremes, value ignored on playback
    push_request(KIND_PLAY,   32'hDEAD_BEEF);
    push_request(KIND_RECORD, 32'h0000_0000);
    push_request(KIND_PLAY,   32'h0);
    push_request(KIND_PLAY,   32'h0);
    push_request(KIND_RECORD, 32'hFFFF_FFFF);
    push_request(KIND_RECORD, 32'hFFFF_FFFF);
    push_request(KIND_RECORD, 32'h8000_0000);
    push_request(KIND_RECORD, 32'h0000_0001);
    push_request(KIND_PLAY,   32'hFFFF_FFFF);
    push_request(KIND_PLAY,   32'h0);
    push_request(KIND_PLAY,   32'h0);
    push_request(KIND_PLAY,   32'h0);
    push_request(KIND_PLAY,   32'h0);
    // extending a run that playback already walked past
    push_request(KIND_RECORD, 32'h0000_0001);
    push_request(KIND_PLAY,   32'h0);
    push_request(KIND_RECORD, 32'h5A5A_5A5A);
    push_request(KIND_PLAY,   32'h0);
    push_request(KIND_PLAY,   32'h0);
    push_request(KIND_RECORD, 32'hA5A5_A5A5);
    push_request(KIND_PLAY,   32'h1234_5678);
    push_request(KIND_RECORD, 32'h7FFF_FFFF);
    push_request(KIND_RECORD, 32'hFFFF_FFFE);
    push_request(KIND_PLAY,   32'h0);

    // run at its limit: 257 equal samples split into 255 plus 2, then walk them back
    for (i = 0; i < MAX_RUN + 2; i++) push_request(KIND_RECORD, 32'h1234_5678);
    for (i = 0; i < 8; i++) push_request(KIND_PLAY, '0);

    // random traffic built from bursts: runs of equal samples (a few past the
    // limit), playback bursts (some long enough to catch up), single noise requests
    budget = 0;
    while (budget < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        len = ($urandom_range(0, 24) == 0) ? $urandom_range(250, 262) : $urandom_range(1, 6);
        v   = ($urandom_range(0, 1) == 0) ? pool[$urandom_range(0, 3)] : $urandom();
        for (i = 0; i < len; i++) begin
          // an occasional stray sample breaks the run
          if ($urandom_range(0, 15) == 0) push_request(KIND_RECORD, $urandom());
          else push_request(KIND_RECORD, v);
        end
        budget += len;
      end else if (sel < 88) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 8);
        for (i = 0; i < len; i++) push_request(KIND_PLAY, $urandom());
        budget += len;
      end else begin
        push_request(($urandom_range(0, 1) == 0) ? KIND_RECORD : KIND_PLAY, $urandom());
        budget++;
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // fill the store: every new value closes a run until no room is left,
    // the last few are dropped
    drain_requests();
    need = RUN_DEPTH - closed_runs + 4;
    for (i = 0; i < need; i++) begin
      v = 32'h3C00_0000 ^ i;
      if (i == 0 && v == open_val) v = ~v;
      push_request(KIND_RECORD, v);
      if (i % 16 == 15) push_request(KIND_PLAY, '0);
    end

    // store full: the open run still grows up to its limit, then equal samples drop too
    drain_requests();
    need = MAX_RUN - open_len + 3;
    v    = open_val;
    for (i = 0; i < need; i++) push_request(KIND_RECORD, v);
    push_request(KIND_RECORD, ~v);
    push_request(KIND_RECORD, $urandom());
    for (i = 0; i < 40; i++) push_request(KIND_PLAY, $urandom());

    drain_requests();
    repeat (8) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    end

    $display("covered %0d transfers: %0d recorded, %0d played, %0d past end, %0d dropped",
             n_accepted, n_status[ST_RECORDED], n_status[ST_PLAYED],
             n_status[ST_FINISHED], n_status[ST_FULL]);
    $display("peak of %0d runs held, %0d mismatches", peak_runs, n_errors);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/rlrp_pkg.sv
rtl/rlrp_core.sv
rtl/run_length_record_playback_top.sv
tb/run_length_record_playback_top_tb.sv
